FILE: rtl/core/bloom_filter_engine_macros.svh
// Assertion macros for the bloom filter engine.
// Used by the top level only; no other dependencies.
`ifndef BLOOM_FILTER_ENGINE_MACROS_SVH
`define BLOOM_FILTER_ENGINE_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define BFE_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define BFE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bfe_pkg.sv
// Shared types and constants for the bloom filter engine.
// No dependencies.
`default_nettype none
package bfe_pkg;
    localparam int unsigned MaxBits   = 1048576;
    localparam int unsigned StoreBytes = MaxBits / 8;
    localparam int unsigned AddrW     = $clog2(StoreBytes);
    localparam int unsigned IdxW      = $clog2(MaxBits);
    localparam int unsigned SizeW     = 21;
    localparam int unsigned CountW    = 6;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpLookup = 2'd1;
    localparam logic [1:0] OpClear  = 2'd2;
    localparam logic [1:0] OpUnused = 2'd3;

    localparam logic CfgNumBits   = 1'b0;
    localparam logic CfgHashCount = 1'b1;

    // Queue entry between front and back.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
    } t_cmd;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/bfe_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bfe_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/bfe_queue.sv
// Two-entry command queue that decouples the front from the back.
// Depends on bfe_pkg.
`default_nettype none
module bfe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bfe_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bfe_pkg::t_cmd      o_cmd
);
    bfe_pkg::t_cmd r_ent [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_ent[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

FILE: rtl/core/bfe_hash.sv
// Multi-cycle MurmurHash3 x86_32 of a 64-bit key, one multiply per cycle,
// followed by a restoring modulo by the filter size. Depends on bfe_pkg.
`default_nettype none
module bfe_hash (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [63:0]               i_key,
    input  wire logic [31:0]               i_seed,
    input  wire logic [bfe_pkg::SizeW-1:0] i_size,
    output logic                           o_done,
    output logic [bfe_pkg::IdxW-1:0]       o_idx
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MIX  = 5'b00010,
        S_FIN  = 5'b00100,
        S_MOD  = 5'b01000,
        S_DONE = 5'b10000
    } t_hstate;

    t_hstate     r_st, n_st;
    logic [3:0]  r_step, n_step;
    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic [20:0] r_rem, n_rem;   // remainder shifted in MSB first
    logic [4:0]  r_bit, n_bit;
    logic [31:0] w_mul_a, w_mul_b, w_prod;
    logic [21:0] w_trial;

    assign w_prod = w_mul_a * w_mul_b;
    assign o_done = (r_st == S_DONE);
    assign o_idx  = r_rem[bfe_pkg::IdxW-1:0];
    assign w_trial = {r_rem, r_h[r_bit]} - {1'b0, i_size};

    always_comb begin
        w_mul_a = r_k;
        w_mul_b = 32'hcc9e2d51;
        unique case (r_step)
            4'd0, 4'd5: begin w_mul_a = r_k; w_mul_b = 32'hcc9e2d51; end
            4'd1, 4'd6: begin w_mul_a = bfe_pkg::rotl32(r_k, 15); w_mul_b = 32'h1b873593; end
            4'd2, 4'd7: begin w_mul_a = bfe_pkg::rotl32(r_h ^ r_k, 13); w_mul_b = 32'd5; end
            4'd3:       begin w_mul_a = r_h ^ (r_h >> 16); w_mul_b = 32'h85ebca6b; end
            4'd4:       begin w_mul_a = r_h ^ (r_h >> 13); w_mul_b = 32'hc2b2ae35; end
            default:    begin w_mul_a = r_k; w_mul_b = 32'hcc9e2d51; end
        endcase
    end

    always_comb begin
        n_st = r_st; n_step = r_step; n_h = r_h; n_k = r_k; n_rem = r_rem; n_bit = r_bit;
        unique case (r_st)
            S_IDLE: if (i_start) begin
                n_st = S_MIX; n_step = 4'd0; n_h = i_seed; n_k = i_key[31:0];
            end
            S_MIX: begin
                // block steps 0..2 first word, 5..7 second word
                unique case (r_step)
                    4'd0, 4'd5: begin n_k = w_prod; n_step = r_step + 4'd1; end
                    4'd1, 4'd6: begin n_k = w_prod; n_step = r_step + 4'd1; end
                    4'd2: begin
                        n_h = w_prod + 32'he6546b64; n_k = i_key[63:32]; n_step = 4'd5;
                    end
                    4'd7: begin
                        n_h = (w_prod + 32'he6546b64) ^ 32'd8; n_step = 4'd3; n_st = S_FIN;
                    end
                    default: n_step = 4'd0;
                endcase
            end
            S_FIN: begin
                if (r_step == 4'd3) begin
                    n_h = w_prod; n_step = 4'd4;
                end else begin
                    n_h = w_prod ^ (w_prod >> 16);
                    n_rem = '0; n_bit = 5'd31; n_st = S_MOD;
                end
            end
            S_MOD: begin
                // one quotient bit per cycle
                if (w_trial[21]) n_rem = {r_rem[19:0], r_h[r_bit]};
                else             n_rem = w_trial[20:0];
                if (r_bit == 5'd0) n_st = S_DONE;
                else n_bit = r_bit - 5'd1;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_step <= 4'd0;
        end else begin
            r_st <= n_st;
            r_step <= n_step;
        end
        r_h <= n_h; r_k <= n_k; r_rem <= n_rem; r_bit <= n_bit;
    end
endmodule
`default_nettype wire

FILE: rtl/core/bfe_back.sv
// Back end: runs hash rounds, read-modify-write on the byte store, clear
// sweeps and the result register. Depends on bfe_pkg, bfe_hash, bfe_ram.
`default_nettype none
module bfe_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire bfe_pkg::t_cmd              i_cmd,
    input  wire logic [bfe_pkg::SizeW-1:0]  i_size,
    input  wire logic [bfe_pkg::CountW-1:0] i_count,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_found,
    output logic [1:0]                      o_done_opcode,
    output logic                            o_busy
);
    typedef enum logic [7:0] {
        S_INIT  = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_HASH  = 8'b00000100,
        S_READ  = 8'b00001000,
        S_WRITE = 8'b00010000,
        S_CLEAR = 8'b00100000,
        S_RES   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state                    r_st, n_st;
    bfe_pkg::t_cmd             r_cmd;
    logic [bfe_pkg::CountW-1:0] r_round;
    logic [bfe_pkg::AddrW:0]   r_caddr;
    logic [bfe_pkg::AddrW:0]   r_cend;
    logic [bfe_pkg::IdxW-1:0]  r_idx;
    logic                      r_found;
    logic                      r_wait;
    logic                      w_hstart, w_hdone, w_we;
    logic [bfe_pkg::IdxW-1:0]  w_hidx;
    logic [bfe_pkg::AddrW-1:0] w_addr;
    logic [7:0]                w_wdata, w_rdata, w_mask;
    logic [bfe_pkg::SizeW-1:0] w_size;
    logic [bfe_pkg::SizeW-1:0] w_csum;

    // saturate size to [8, MaxBits]
    always_comb begin
        if (i_size < bfe_pkg::SizeW'(8)) w_size = bfe_pkg::SizeW'(8);
        else if (i_size > bfe_pkg::SizeW'(bfe_pkg::MaxBits)) w_size = bfe_pkg::SizeW'(bfe_pkg::MaxBits);
        else w_size = i_size;
    end
    assign w_csum = w_size + bfe_pkg::SizeW'(7);

    assign w_hstart = (r_st == S_HASH) && !r_wait;
    bfe_hash u_hash (
        .i_clk, .i_rst_n, .i_start(w_hstart), .i_key(r_cmd.key),
        .i_seed({26'd0, r_round}), .i_size(w_size), .o_done(w_hdone), .o_idx(w_hidx)
    );

    assign w_mask = 8'h80 >> r_idx[2:0];
    always_comb begin
        w_we = 1'b0; w_wdata = w_rdata | w_mask; w_addr = r_idx[bfe_pkg::IdxW-1:3];
        if (r_st == S_INIT || r_st == S_CLEAR) begin
            w_we = 1'b1; w_wdata = 8'h00; w_addr = r_caddr[bfe_pkg::AddrW-1:0];
        end else if (r_st == S_WRITE && r_cmd.opcode == bfe_pkg::OpInsert) begin
            w_we = 1'b1;
        end
    end

    bfe_ram #(.Width(8), .Depth(bfe_pkg::StoreBytes)) u_ram (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_found = r_found;
    assign o_done_opcode = r_cmd.opcode;
    assign o_busy = (r_st != S_IDLE);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_INIT:  if (r_caddr == (bfe_pkg::AddrW+1)'(bfe_pkg::StoreBytes - 1)) n_st = S_IDLE;
            S_IDLE: if (i_valid) begin
                priority if (i_cmd.opcode == bfe_pkg::OpInsert || i_cmd.opcode == bfe_pkg::OpLookup)
                    n_st = (i_count == '0) ? S_OUT : S_HASH;
                else if (i_cmd.opcode == bfe_pkg::OpClear) n_st = S_CLEAR;
                else n_st = S_OUT;
            end
            S_HASH:  if (w_hdone) n_st = S_READ;
            S_READ:  n_st = S_WRITE;
            S_WRITE: n_st = S_RES;
            S_RES: begin
                if (r_cmd.opcode == bfe_pkg::OpLookup && !r_found) n_st = S_OUT;
                else if (r_round == i_count) n_st = S_OUT;
                else n_st = S_HASH;
            end
            S_CLEAR: if (r_caddr + 1'b1 >= r_cend) n_st = S_OUT;
            S_OUT:   if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_caddr <= '0;
            r_wait <= 1'b0;
        end else begin
            r_st <= n_st;
            r_wait <= (r_st == S_HASH) ? !w_hdone : 1'b0;
            if (r_st == S_INIT || r_st == S_CLEAR) r_caddr <= r_caddr + 1'b1;
            else r_caddr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid) begin
            r_cmd <= i_cmd;
            r_round <= '0;
            r_found <= (i_cmd.opcode != bfe_pkg::OpUnused);
            r_cend <= (bfe_pkg::AddrW+1)'(w_csum >> 3);
        end
        if (r_st == S_HASH && w_hdone) r_idx <= w_hidx;
        if (r_st == S_WRITE) begin
            r_round <= r_round + 1'b1;
            if (r_cmd.opcode == bfe_pkg::OpLookup && (w_rdata & w_mask) == 8'h00)
                r_found <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/bfe_front.sv
// Front end: configuration registers and input acceptance into the queue.
// Depends on bfe_pkg.
`default_nettype none
module bfe_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [63:0]                i_key,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_index,
    input  wire logic                       i_cfg_hi,
    input  wire logic [31:0]                i_cfg_data,
    output logic                            o_q_valid,
    input  wire logic                       i_q_ready,
    output bfe_pkg::t_cmd                   o_q_cmd,
    output logic [bfe_pkg::SizeW-1:0]       o_size,
    output logic [bfe_pkg::CountW-1:0]      o_count
);
    logic [bfe_pkg::SizeW-1:0]  r_size;
    logic [bfe_pkg::CountW-1:0] r_count;

    assign o_ready     = i_q_ready;
    assign o_q_valid   = i_valid;
    assign o_q_cmd     = '{opcode: i_opcode, key: i_key};
    assign o_cfg_ready = 1'b1;
    assign o_size      = r_size;
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= bfe_pkg::SizeW'(bfe_pkg::MaxBits);
            r_count <= bfe_pkg::CountW'(7);
        end else if (i_cfg_valid && !i_cfg_hi) begin
            // indexes beyond the list are dropped
            unique case (i_cfg_index)
                bfe_pkg::CfgNumBits:   r_size  <= i_cfg_data[bfe_pkg::SizeW-1:0];
                bfe_pkg::CfgHashCount: r_count <= i_cfg_data[bfe_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/bloom_filter_engine.sv
// Bloom filter engine top level. An accepted item waits in the two-entry queue
// until the back end takes it. Each hash round runs the hash, the modulo and a
// read-modify-write of one store byte; insert/lookup show a result after their
// rounds, lookup stopping at the first clear bit. Clear zeroes each byte in use.
// One item at a time: the next one starts only after the result is taken.
// After reset a clearing pass zeroes the whole store before items run.
`default_nettype none
`include "bloom_filter_engine_macros.svh"
module bloom_filter_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [63:0] i_key,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [1:0]       o_done_opcode
);
    logic                       w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready, w_busy;
    bfe_pkg::t_cmd              w_fq_cmd, w_qb_cmd;
    logic [bfe_pkg::SizeW-1:0]  w_size;
    logic [bfe_pkg::CountW-1:0] w_count;

    bfe_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_key,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index(i_cfg_index[0]),
        .i_cfg_hi(i_cfg_index[31:1] != 31'd0), .i_cfg_data,
        .o_q_valid(w_fq_valid), .i_q_ready(w_fq_ready), .o_q_cmd(w_fq_cmd),
        .o_size(w_size), .o_count(w_count)
    );

    bfe_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fq_valid), .o_ready(w_fq_ready), .i_cmd(w_fq_cmd),
        .o_valid(w_qb_valid), .i_ready(w_qb_ready), .o_cmd(w_qb_cmd)
    );

    bfe_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qb_valid), .o_ready(w_qb_ready), .i_cmd(w_qb_cmd),
        .i_size(w_size), .i_count(w_count), .o_valid, .i_ready, .o_found, .o_done_opcode,
        .o_busy(w_busy)
    );

    `BFE_ASSERT_IMP(a_out_busy, i_clk, i_rst_n, o_valid, w_busy, "result shown while back idle")
    `BFE_ASSERT_NEXT(a_take, i_clk, i_rst_n, w_qb_valid && w_qb_ready, w_busy, "back took no item")
    `BFE_ASSERT_IMP(a_bad_op, i_clk, i_rst_n, o_valid && o_done_opcode == bfe_pkg::OpUnused, !o_found,
        "unused opcode reported found")
endmodule
`default_nettype wire
